@@ src/imu_vc_pkg.sv @@
// Shared types, register indexes and reset values for the IMU vibration classifier.
`default_nettype none

package imu_vc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_OFFSET_Z = 3'd2,
        CFG_SUDDEN   = 3'd3,
        CFG_STILL    = 3'd4,
        CFG_LOW      = 3'd5,
        CFG_HIGH     = 3'd6,
        CFG_DEADBAND = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        LVL_STILL  = 3'd0,
        LVL_LOW    = 3'd1,
        LVL_MEDIUM = 3'd2,
        LVL_HIGH   = 3'd3,
        LVL_SUDDEN = 3'd4
    } t_level;

    typedef logic signed [16:0] t_corr;
    typedef logic signed [17:0] t_rate;

    // Reset values; limits are kept squared for the magnitude compare.
    localparam logic [15:0] OffsetXRst  = 16'd2294;
    localparam logic [15:0] OffsetYRst  = 16'hFEB8;
    localparam logic [15:0] OffsetZRst  = 16'hC3D7;
    localparam logic [15:0] SuddenRst   = 16'd29491;
    localparam logic [31:0] StillSqRst  = 32'd2683044;
    localparam logic [31:0] LowSqRst    = 32'd67108864;
    localparam logic [31:0] HighSqRst   = 32'd268435456;
    localparam logic [14:0] DeadbandRst = 15'd14;

endpackage

`default_nettype wire

@@ src/imu_vibration_classifier.sv @@
// Top level of the IMU vibration classifier: offset, gyro smoothing, level and alert.
// Pipeline: an accepted beat goes through the input stage and then the result stage, both registered.
// Throughput: one beat per cycle unless the result channel stalls; each stage has its own valid and
//   advances when the next is empty or drained; an empty input stage takes a beat while a result waits.
// Reset (synchronous, active low): pipeline emptied, previous acceleration and gyro averages
//   zeroed, alert off, configuration back to its defaults (limits stored squared).
`default_nettype none

module imu_vibration_classifier
    import imu_vc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write channel
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    // sample input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [15:0]  i_accel_x,
    input  wire logic signed [15:0]  i_accel_y,
    input  wire logic signed [15:0]  i_accel_z,
    input  wire logic signed [15:0]  i_gyro_x,
    input  wire logic signed [15:0]  i_gyro_y,
    input  wire logic signed [15:0]  i_gyro_z,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [16:0]       o_corr_x,
    output logic signed [16:0]       o_corr_y,
    output logic signed [16:0]       o_corr_z,
    output logic signed [17:0]       o_rate_x,
    output logic signed [17:0]       o_rate_y,
    output logic signed [17:0]       o_rate_z,
    output logic [2:0]               o_level,
    output logic                     o_alert
);

    // ------------------------------------------------------------------
    // Configuration registers. Config beats are always taken. The user must
    // keep the block idle whenever they arrive; the block does not enforce it.
    // The squared limits then settle before the next sample reaches the result stage.
    // ------------------------------------------------------------------
    logic [15:0] r_offset [3];
    logic [15:0] r_sudden_limit;
    logic [31:0] r_still_sq;
    logic [31:0] r_low_sq;
    logic [31:0] r_high_sq;
    logic [14:0] r_deadband;
    logic [31:0] w_cfg_sq;
    logic        w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_cfg_sq    = 32'(i_cfg_data) * 32'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0]    <= OffsetXRst;
            r_offset[1]    <= OffsetYRst;
            r_offset[2]    <= OffsetZRst;
            r_sudden_limit <= SuddenRst;
            r_still_sq     <= StillSqRst;
            r_low_sq       <= LowSqRst;
            r_high_sq      <= HighSqRst;
            r_deadband     <= DeadbandRst;
        end else if (w_cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET_X: r_offset[0]    <= i_cfg_data;
                CFG_OFFSET_Y: r_offset[1]    <= i_cfg_data;
                CFG_OFFSET_Z: r_offset[2]    <= i_cfg_data;
                CFG_SUDDEN:   r_sudden_limit <= i_cfg_data;
                CFG_STILL:    r_still_sq     <= w_cfg_sq;
                CFG_LOW:      r_low_sq       <= w_cfg_sq;
                CFG_HIGH:     r_high_sq      <= w_cfg_sq;
                CFG_DEADBAND: r_deadband     <= i_cfg_data[14:0];
                default:      r_deadband     <= r_deadband;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_ready;
    logic w_s2_ready;
    logic w_in_take;
    logic w_s2_load;

    assign w_s2_ready = !r_out_valid || i_out_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_in_take  = i_in_valid && w_s1_ready;
    assign w_s2_load  = r_s1_valid && w_s2_ready;
    assign o_in_ready = w_s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: offset correction, per-axis jump test, gyro deadband and
    // half-weight average. The stage registers double as the state: the
    // corrected values are the previous acceleration for the next beat
    // and the rate registers are the running averages.
    // ------------------------------------------------------------------
    logic signed [15:0] w_accel [3];
    logic signed [15:0] w_gyro  [3];
    t_corr              r_last_corr [3];
    t_rate              r_rate_avg  [3];
    logic               r_s1_sudden;
    t_corr              n_corr [3];
    t_rate              n_rate [3];
    logic               n_sudden;

    assign w_accel[0] = i_accel_x;
    assign w_accel[1] = i_accel_y;
    assign w_accel[2] = i_accel_z;
    assign w_gyro[0]  = i_gyro_x;
    assign w_gyro[1]  = i_gyro_y;
    assign w_gyro[2]  = i_gyro_z;

    always_comb begin
        logic signed [17:0] diff;
        logic        [17:0] diff_abs;
        logic        [16:0] g_abs;
        logic signed [15:0] g_kept;
        logic signed [18:0] sum;
        n_sudden = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_corr[i] = {w_accel[i][15], w_accel[i]} + {r_offset[i][15], r_offset[i]};
            diff      = {n_corr[i][16], n_corr[i]} - {r_last_corr[i][16], r_last_corr[i]};
            diff_abs  = diff[17] ? 18'(-diff) : 18'(diff);
            if (diff_abs > {2'b00, r_sudden_limit}) begin
                n_sudden = 1'b1;
            end

            g_abs  = w_gyro[i][15] ? 17'(-{w_gyro[i][15], w_gyro[i]})
                                   : {w_gyro[i][15], w_gyro[i]};
            g_kept = (g_abs < {2'b00, r_deadband}) ? 16'sd0 : w_gyro[i];
            // 4*g plus old average, then arithmetic halving (floor)
            sum       = {g_kept[15], g_kept, 2'b00} + {r_rate_avg[i][17], r_rate_avg[i]};
            n_rate[i] = sum[18:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_sudden <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_last_corr[i] <= '0;
                r_rate_avg[i]  <= '0;
            end
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_in_take) begin
                r_s1_sudden <= n_sudden;
                for (int i = 0; i < 3; i++) begin
                    r_last_corr[i] <= n_corr[i];
                    r_rate_avg[i]  <= n_rate[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared magnitude against squared limits, level and alert.
    // Three parallel 17x17 squares, one 34-bit sum, three compares.
    // ------------------------------------------------------------------
    logic [33:0] w_m2;
    t_level      n_level;
    logic        n_alert;
    t_corr       r_corr [3];
    t_rate       r_rate [3];
    t_level      r_level;
    logic        r_alert;

    always_comb begin
        logic signed [33:0] sq;
        w_m2 = '0;
        for (int i = 0; i < 3; i++) begin
            sq   = r_last_corr[i] * r_last_corr[i];
            w_m2 = w_m2 + {1'b0, sq[32:0]};
        end
    end

    always_comb begin
        n_level = LVL_MEDIUM;
        n_alert = r_alert;
        if (r_s1_sudden) begin
            n_level = LVL_SUDDEN;
            n_alert = 1'b1;
        end else if (w_m2 < {2'b00, r_still_sq}) begin
            n_level = LVL_STILL;
            n_alert = 1'b0;
        end else if (w_m2 < {2'b00, r_low_sq}) begin
            n_level = LVL_LOW;
            n_alert = 1'b0;
        end else if (w_m2 >= {2'b00, r_high_sq}) begin
            n_level = LVL_HIGH;
            n_alert = 1'b0;
        end
    end

    // The alert output register is also the alert state carried between beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_alert     <= 1'b0;
            r_level     <= LVL_STILL;
        end else begin
            if (w_s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s2_load) begin
                r_alert <= n_alert;
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            for (int i = 0; i < 3; i++) begin
                r_corr[i] <= r_last_corr[i];
                r_rate[i] <= r_rate_avg[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_corr_x    = r_corr[0];
    assign o_corr_y    = r_corr[1];
    assign o_corr_z    = r_corr[2];
    assign o_rate_x    = r_rate[0];
    assign o_rate_y    = r_rate[1];
    assign o_rate_z    = r_rate[2];
    assign o_level     = r_level;
    assign o_alert     = r_alert;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_sudden_sets_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_level == LVL_SUDDEN) |-> o_alert)
        else $error("sudden result without alert");

    a_quiet_clears_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_level == LVL_STILL || o_level == LVL_LOW || o_level == LVL_HIGH))
        |-> !o_alert)
        else $error("alert left on after still, low or high result");

    a_medium_holds_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_load && n_level == LVL_MEDIUM) |=> (o_alert == $past(o_alert)))
        else $error("alert changed on medium result");

    a_stage_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_load |=> o_out_valid)
        else $error("result stage not valid after load");

endmodule

`default_nettype wire
